/* design/otr_pkg.sv */
// Package for the one-wire temperature reader.
// Holds the configuration and result types, command codes and the CRC-8 step.
// No dependencies.
package otr_pkg;

   // Scratchpad size, the bus commands of a reading and the CRC polynomial
   localparam int unsigned PAD_BYTES = 9;
   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT = 8'h44;
   localparam logic [7:0] CMD_READ_PAD = 8'hBE;
   localparam logic [7:0] CRC_POLY = 8'h8C;

   // Input operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_START = 1'b1;

   // Slot kinds shown on the result
   localparam logic [1:0] SLOT_NONE = 2'd0;
   localparam logic [1:0] SLOT_WRITE_ONE = 2'd1;
   localparam logic [1:0] SLOT_READ = 2'd2;

   // Register indexes on the CSR port
   localparam logic [2:0] CSR_RESET_LOW = 3'd0;
   localparam logic [2:0] CSR_RECOVERY = 3'd1;
   localparam logic [2:0] CSR_PRESENCE_TO = 3'd2;
   localparam logic [2:0] CSR_RELEASE_TO = 3'd3;
   localparam logic [2:0] CSR_SLOT = 3'd4;
   localparam logic [2:0] CSR_EXP_CONFIG = 3'd5;

   typedef struct packed {
      logic [7:0] reset_low_ticks;
      logic [7:0] recovery_ticks;
      logic [7:0] presence_timeout;
      logic [7:0] release_timeout;
      logic [7:0] slot_ticks;
      logic [7:0] expected_config_byte;
   } cfg_type;

   typedef struct packed {
      logic              drive_low;
      logic [1:0]        slot_kind;
      logic              busy_res;
      logic              done_res;
      logic              ok;
      logic signed [15:0] temperature;
      logic [2:0]        active_line;
   } result_type;

   // Dallas CRC-8, reflected polynomial, one byte
   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* design/otr_req_if.sv */
// Request channel interface of the one-wire temperature reader.
// Carries the handshake and the tick or start fields; no dependencies.
interface otr_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [2:0] channel;
   logic       line_high;

   modport source (output valid, output op, output channel, output line_high, input ready);
   modport sink (input valid, input op, input channel, input line_high, output ready);
endinterface

/* design/otr_rsp_if.sv */
// Response channel interface of the one-wire temperature reader.
// Carries the handshake and the result fields; no dependencies.
interface otr_rsp_if;
   logic              valid;
   logic              ready;
   logic              drive_low;
   logic [1:0]        slot_kind;
   logic              busy_res;
   logic              done_res;
   logic              ok;
   logic signed [15:0] temperature;
   logic [2:0]        active_line;

   modport source (output valid, output drive_low, output slot_kind, output busy_res,
                   output done_res, output ok, output temperature, output active_line,
                   input ready);
   modport sink (input valid, input drive_low, input slot_kind, input busy_res,
                 input done_res, input ok, input temperature, input active_line,
                 output ready);
endinterface

/* design/otr_csr.sv */
// Configuration registers of the one-wire temperature reader.
// Depends on otr_pkg for the register indexes and cfg_type.
module otr_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   output otr_pkg::cfg_type  cfg
);
   import otr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RESET_LOW:   cfg_in.reset_low_ticks = csr_wdata;
            CSR_RECOVERY:    cfg_in.recovery_ticks = csr_wdata;
            CSR_PRESENCE_TO: cfg_in.presence_timeout = csr_wdata;
            CSR_RELEASE_TO:  cfg_in.release_timeout = csr_wdata;
            CSR_SLOT:        cfg_in.slot_ticks = csr_wdata;
            CSR_EXP_CONFIG:  cfg_in.expected_config_byte = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks <= 8'd52;
         cfg_ff.recovery_ticks <= 8'd6;
         cfg_ff.presence_timeout <= 8'd8;
         cfg_ff.release_timeout <= 8'd30;
         cfg_ff.slot_ticks <= 8'd6;
         cfg_ff.expected_config_byte <= 8'h7F;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/otr_seq.sv */
// Bus sequencer of the one-wire temperature reader: reset, command and
// read-slot phases, scratchpad capture and CRC check, one step per transfer.
// Depends on otr_pkg for cfg_type, result_type, commands and crc_byte.
module otr_seq #(
   parameter int unsigned NUM_LINES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                op,
   input  logic [2:0]          channel,
   input  logic                line_high,
   input  otr_pkg::cfg_type    cfg,
   output otr_pkg::result_type res
);
   import otr_pkg::*;

   // Phase codes
   localparam logic [6:0] PH_START = 7'd0;
   localparam logic [6:0] PH_BEGIN = 7'd1;
   localparam logic [6:0] PH_SKIP1 = 7'd2;
   localparam logic [6:0] PH_CONV = 7'd3;
   localparam logic [6:0] PH_RESET2 = 7'd4;
   localparam logic [6:0] PH_SKIP2 = 7'd5;
   localparam logic [6:0] PH_RDCMD = 7'd6;
   localparam logic [6:0] PH_RDPAD = 7'd7;
   localparam logic [6:0] PH_CHECK = 7'd8;
   localparam logic [6:0] PH_DONE = 7'd9;
   localparam logic [6:0] PH_IDLE = 7'd10;
   localparam logic [6:0] PH_ERR = 7'd99;
   localparam logic [6:0] PH_RST0 = 7'd100;
   localparam logic [6:0] PH_RST1 = 7'd101;
   localparam logic [6:0] PH_RST2 = 7'd102;
   localparam logic [6:0] PH_RST3 = 7'd103;
   localparam logic [6:0] PH_RST4 = 7'd104;
   localparam logic [6:0] PH_RST5 = 7'd105;
   localparam logic [6:0] PH_WR0 = 7'd110;
   localparam logic [6:0] PH_WR1 = 7'd111;
   localparam logic [6:0] PH_WR2 = 7'd112;
   localparam logic [6:0] PH_WR3 = 7'd113;
   localparam logic [6:0] PH_RD0 = 7'd120;
   localparam logic [6:0] PH_RD1 = 7'd121;
   localparam logic [6:0] PH_RD2 = 7'd122;
   localparam logic [6:0] PH_RD3 = 7'd123;
   localparam logic [6:0] PH_RD4 = 7'd124;
   localparam logic [6:0] PH_RD5 = 7'd125;

   localparam logic [3:0] LINES_LIMIT = 4'(NUM_LINES);
   localparam logic [3:0] PAD_LAST = 4'(PAD_BYTES - 1);
   localparam logic [3:0] PAD_COUNT = 4'(PAD_BYTES);

   logic [6:0]  phase_ff, phase_in;
   logic [6:0]  ret_ff, ret_in;
   logic [7:0]  tick_ff, tick_in;
   logic [7:0]  tx_ff, tx_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  rx_ff, rx_in;
   logic [3:0]  byte_ff, byte_in;
   logic [7:0]  crc_ff, crc_in;
   logic [2:0]  line_ff, line_in;
   logic [15:0] reading_ff, reading_in;
   logic        good_ff, good_in;

   logic [7:0]  pad_ff [PAD_BYTES];
   logic        pad_we;
   logic [3:0]  pad_addr;

   logic [1:0]  kind;
   logic        done;

   // Next state for one transfer
   always_comb begin
      phase_in = phase_ff;
      ret_in = ret_ff;
      tick_in = tick_ff;
      tx_in = tx_ff;
      bit_in = bit_ff;
      rx_in = rx_ff;
      byte_in = byte_ff;
      crc_in = crc_ff;
      line_in = line_ff;
      reading_in = reading_ff;
      good_in = good_ff;
      pad_we = 1'b0;
      pad_addr = byte_ff;
      kind = SLOT_NONE;
      done = 1'b0;

      if (accept) begin
         if (op == OP_START) begin
            // Restart on a valid line; ignore others
            if ({1'b0, channel} < LINES_LIMIT) begin
               line_in = channel;
               good_in = 1'b0;
               phase_in = PH_START;
               tick_in = 8'd0;
            end
         end else begin
            if (tick_ff != 8'hFF) begin
               tick_in = tick_ff + 8'd1;
            end
            unique case (phase_ff)
               PH_START: phase_in = PH_BEGIN;
               PH_BEGIN, PH_RESET2: begin
                  ret_in = phase_ff + 7'd1;
                  tx_in = 8'd0;
                  phase_in = PH_RST0;
               end
               PH_SKIP1, PH_SKIP2: begin
                  ret_in = phase_ff + 7'd1;
                  tx_in = CMD_SKIP_ROM;
                  phase_in = PH_WR0;
               end
               PH_CONV: begin
                  ret_in = phase_ff + 7'd1;
                  tx_in = CMD_CONVERT;
                  phase_in = PH_WR0;
               end
               PH_RDCMD: begin
                  ret_in = phase_ff + 7'd1;
                  tx_in = CMD_READ_PAD;
                  phase_in = PH_WR0;
               end
               PH_RDPAD: begin
                  ret_in = phase_ff + 7'd1;
                  tx_in = 8'd0;
                  phase_in = PH_RD0;
               end
               PH_CHECK: begin
                  // Accept the reading only if CRC and config byte match
                  if (crc_ff == pad_ff[8] && pad_ff[4] == cfg.expected_config_byte) begin
                     reading_in = {pad_ff[1], pad_ff[0]};
                     good_in = 1'b1;
                  end else begin
                     good_in = 1'b0;
                  end
                  phase_in = PH_DONE;
               end
               PH_DONE: begin
                  phase_in = PH_IDLE;
                  done = 1'b1;
               end
               PH_IDLE: phase_in = PH_IDLE;
               PH_ERR: begin
                  good_in = 1'b0;
                  phase_in = PH_DONE;
               end
               PH_RST0: begin
                  tick_in = 8'd0;
                  phase_in = PH_RST1;
               end
               PH_RST1: begin
                  if (tick_in >= cfg.reset_low_ticks) begin
                     tick_in = 8'd0;
                     phase_in = PH_RST2;
                  end
               end
               PH_RST2: begin
                  if (tick_in >= cfg.recovery_ticks || line_high) begin
                     tick_in = 8'd0;
                     phase_in = PH_RST3;
                  end
               end
               PH_RST3: begin
                  // Wait for the presence pulse
                  if (!line_high) begin
                     tick_in = 8'd0;
                     phase_in = PH_RST4;
                  end else if (tick_in > cfg.presence_timeout) begin
                     phase_in = PH_ERR;
                  end
               end
               PH_RST4: begin
                  // Wait for the sensor to release the line
                  if (line_high) begin
                     tick_in = 8'd0;
                     phase_in = PH_RST5;
                  end else if (tick_in > cfg.release_timeout) begin
                     phase_in = PH_ERR;
                  end
               end
               PH_RST5, PH_WR3, PH_RD5: phase_in = ret_ff;
               PH_WR0: begin
                  bit_in = 4'd0;
                  phase_in = PH_WR1;
               end
               PH_WR1: begin
                  if (tx_ff[0]) begin
                     kind = SLOT_WRITE_ONE;
                  end
                  tick_in = 8'd0;
                  phase_in = PH_WR2;
               end
               PH_WR2: begin
                  if (tick_in >= cfg.slot_ticks) begin
                     tx_in = tx_ff >> 1;
                     bit_in = bit_ff + 4'd1;
                     phase_in = bit_in[3] ? PH_WR3 : PH_WR1;
                  end
               end
               PH_RD0: begin
                  byte_in = 4'd0;
                  crc_in = 8'd0;
                  phase_in = PH_RD1;
               end
               PH_RD1: begin
                  bit_in = 4'd0;
                  rx_in = 8'd0;
                  phase_in = PH_RD2;
               end
               PH_RD2: begin
                  rx_in = rx_ff >> 1;
                  kind = SLOT_READ;
                  tick_in = 8'd0;
                  phase_in = PH_RD3;
               end
               PH_RD3: begin
                  // Sample the bit on the tick after the slot pulse
                  if (tick_in == 8'd1 && line_high) begin
                     rx_in = rx_ff | 8'h80;
                  end
                  if (tick_in >= cfg.slot_ticks) begin
                     bit_in = bit_ff + 4'd1;
                     phase_in = bit_in[3] ? PH_RD4 : PH_RD2;
                  end
               end
               PH_RD4: begin
                  // Store the byte and fold it into the CRC unless it is the last (CRC) byte
                  if (byte_ff <= PAD_LAST) begin
                     pad_we = 1'b1;
                     if (byte_ff < PAD_LAST) begin
                        crc_in = crc_byte(crc_ff, rx_ff);
                     end
                  end
                  byte_in = byte_ff + 4'd1;
                  phase_in = (byte_in >= PAD_COUNT) ? PH_RD5 : PH_RD1;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // Result of this transfer, taken from the updated state
   always_comb begin
      res.drive_low = (phase_in == PH_RST1) || (phase_in == PH_WR2 && !tx_in[0]);
      res.slot_kind = kind;
      res.busy_res = (phase_in != PH_IDLE);
      res.done_res = done;
      res.ok = good_in;
      res.temperature = good_in ? signed'(reading_in) : 16'sd0;
      res.active_line = line_in;
   end

   // Control and data state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ret_ff <= 7'd0;
         tick_ff <= 8'd0;
         tx_ff <= 8'd0;
         bit_ff <= 4'd0;
         rx_ff <= 8'd0;
         byte_ff <= 4'd0;
         crc_ff <= 8'd0;
         line_ff <= 3'd0;
         reading_ff <= 16'd0;
         good_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         ret_ff <= ret_in;
         tick_ff <= tick_in;
         tx_ff <= tx_in;
         bit_ff <= bit_in;
         rx_ff <= rx_in;
         byte_ff <= byte_in;
         crc_ff <= crc_in;
         line_ff <= line_in;
         reading_ff <= reading_in;
         good_ff <= good_in;
      end
   end

   // Scratchpad bytes, written as they arrive
   always_ff @(posedge clock) begin
      if (pad_we) begin
         pad_ff[pad_addr] <= rx_ff;
      end
   end

endmodule

/* design/otr_out_reg.sv */
// Result register of the one-wire temperature reader.
// Holds one result until the response transfer; depends on otr_pkg.
module otr_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  otr_pkg::result_type res_in,
   input  logic                out_ready,
   output logic                in_ready,
   output logic                out_valid,
   output otr_pkg::result_type res_out
);
   import otr_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Take a new result whenever the held one leaves or none is held
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res_in;
      end
   end

   assign out_valid = valid_ff;
   assign res_out = data_ff;

endmodule

/* design/onewire_temp_sensor_reader_unit.sv */
// One-wire temperature reader: result valid in the cycle after the request transfer.
// Throughput one request per cycle unless the response channel stalls; each tick is
// a single step of the phase sequencer, whose result is held in one output register.
// Reset (synchronous, active high) loads the register defaults, idles the sequencer
// and empties the result register; the scratchpad is not cleared.
// Depends on otr_pkg, otr_req_if, otr_rsp_if, otr_csr, otr_seq and otr_out_reg.
module onewire_temp_sensor_reader_unit #(
   parameter int unsigned NUM_LINES = 8
) (
   input  logic       clock,
   input  logic       reset,
   otr_req_if.sink    req_ch,
   otr_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import otr_pkg::*;

   cfg_type    cfg;
   result_type step_res;
   result_type held_res;
   logic       accept;
   logic       stage_ready;
   logic       held_valid;

   otr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Step the sequencer on each request transfer
   assign accept = req_ch.valid && stage_ready;
   assign req_ch.ready = stage_ready;

   otr_seq #(
      .NUM_LINES (NUM_LINES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (req_ch.op),
      .channel   (req_ch.channel),
      .line_high (req_ch.line_high),
      .cfg       (cfg),
      .res       (step_res)
   );

   otr_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .res_in    (step_res),
      .out_ready (rsp_ch.ready),
      .in_ready  (stage_ready),
      .out_valid (held_valid),
      .res_out   (held_res)
   );

   // Drive the response channel
   assign rsp_ch.valid = held_valid;
   assign rsp_ch.drive_low = held_res.drive_low;
   assign rsp_ch.slot_kind = held_res.slot_kind;
   assign rsp_ch.busy_res = held_res.busy_res;
   assign rsp_ch.done_res = held_res.done_res;
   assign rsp_ch.ok = held_res.ok;
   assign rsp_ch.temperature = held_res.temperature;
   assign rsp_ch.active_line = held_res.active_line;

endmodule
